### hdl/peak_hold_bar_meter_top_assert.svh
// Assertion macros used by the peak hold bar meter RTL.
`ifndef PEAK_HOLD_BAR_METER_TOP_ASSERT_SVH
`define PEAK_HOLD_BAR_METER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PHBM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PHBM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hdl/phbm_pkg.sv
// Shared constants, register codes and control structs of the bar meter.
`timescale 1ns / 1ps

package phbm_pkg;

	localparam int BAND_COUNT_DEF = 5;
	localparam int ROW_COUNT_DEF  = 5;
	localparam int OUT_ROWS       = 5;

	localparam int BAND_W     = 3;
	localparam int LVL_W      = 11;
	localparam int GAIN_W     = 8;
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_THRESH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_SCALE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BODY_BASE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BODY_SPAN    = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic upd_h;
		logic upd_p;
		logic peak;
		logic row;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_range;
		logic row_last;
		logic out_free;
	} status_t;

endpackage

### hdl/phbm_ctrl.sv
// Sequencer of the bar meter: steps one transaction through the datapath.
`timescale 1ns / 1ps

module phbm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  phbm_pkg::status_t sts,
	output phbm_pkg::cmd_t   cmd
);
	import phbm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD_H,
		ST_UPD_P,
		ST_PEAK,
		ST_ROWS,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_MUL;
						in_ready_q <= 1'b0;
					end
				end
				ST_MUL: begin
					state_q <= sts.in_range ? ST_UPD_H : ST_DONE;
				end
				ST_UPD_H: state_q <= ST_UPD_P;
				ST_UPD_P: state_q <= ST_PEAK;
				ST_PEAK:  state_q <= ST_ROWS;
				ST_ROWS: begin
					if (sts.row_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	always_comb begin
		cmd      = '0;
		cmd.load = in_ready_q & in_valid;
		unique case (state_q)
			ST_MUL:   cmd.mul   = 1'b1;
			ST_UPD_H: cmd.upd_h = 1'b1;
			ST_UPD_P: cmd.upd_p = 1'b1;
			ST_PEAK:  cmd.peak  = 1'b1;
			ST_ROWS:  cmd.row   = 1'b1;
			ST_DONE:  cmd.out_load = sts.out_free;
			default:  ;
		endcase
	end

endmodule

### hdl/phbm_datapath.sv
// Datapath of the bar meter: config, band state, level update, row render, output.
`timescale 1ns / 1ps

`include "peak_hold_bar_meter_top_assert.svh"

module phbm_datapath #(
	parameter int BAND_COUNT = phbm_pkg::BAND_COUNT_DEF,
	parameter int ROW_COUNT  = phbm_pkg::ROW_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [phbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [phbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [phbm_pkg::BAND_W-1:0]      band_index,
	input  logic [phbm_pkg::LVL_W-1:0]       target_level,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [phbm_pkg::BAND_W-1:0]      column_index,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row0,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row1,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row2,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row3,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row4,
	input  phbm_pkg::cmd_t                   cmd,
	output phbm_pkg::status_t                sts
);
	import phbm_pkg::*;

	localparam int BIDX_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int RW      = $clog2(ROW_COUNT);
	localparam int DIV_SH  = 16;
	// reciprocal of (ROW_COUNT-1), exact for 8-bit numerators
	localparam int RECIP   = (2**DIV_SH + ROW_COUNT - 2) / (ROW_COUNT - 1);
	localparam int TOP_LVL = (ROW_COUNT - 1) * 256 + 128;

	// configuration
	logic [GAIN_W-1:0] attack_gain_q, release_gain_q, snap_thresh_q;
	logic [LVL_W-1:0]  max_height_q;
	logic [7:0]        peak_decay_q, peak_scale_q, body_base_q, body_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_gain_q  <= 8'd77;
			release_gain_q <= 8'd33;
			snap_thresh_q  <= 8'd20;
			max_height_q   <= 11'd1152;
			peak_decay_q   <= 8'd13;
			peak_scale_q   <= 8'd56;
			body_base_q    <= 8'd150;
			body_span_q    <= 8'd105;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK_GAIN:  attack_gain_q  <= cfg_data[7:0];
				REG_RELEASE_GAIN: release_gain_q <= cfg_data[7:0];
				REG_SNAP_THRESH:  snap_thresh_q  <= cfg_data[7:0];
				REG_MAX_HEIGHT:   max_height_q   <= cfg_data;
				REG_PEAK_DECAY:   peak_decay_q   <= cfg_data[7:0];
				REG_PEAK_SCALE:   peak_scale_q   <= cfg_data[7:0];
				REG_BODY_BASE:    body_base_q    <= cfg_data[7:0];
				REG_BODY_SPAN:    body_span_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// per-band state
	logic [LVL_W-1:0] bar_height_q [BAND_COUNT];
	logic [LVL_W-1:0] peak_level_q [BAND_COUNT];

	// working registers
	logic [BAND_W-1:0] band_q;
	logic [LVL_W-1:0]  target_q, h_q, p_q, gap_q;
	logic              in_range_q, rise_q, pnz_q;
	logic [18:0]       prod_q;
	logic [7:0]        qs_q, pb_q;
	logic [RW-1:0]     rs_q, pd_q, d_q, r_acc_q;
	logic [8:0]        q_acc_q;
	logic [PIX_W-1:0]  col_q [OUT_ROWS];
	logic              out_valid_q;

	logic [BIDX_W-1:0] bsel_in, bsel_q;
	assign bsel_in = BIDX_W'(band_index);
	assign bsel_q  = BIDX_W'(band_q);

	// attack / release product
	logic [LVL_W-1:0]  gap_d;
	logic              rise_d;
	logic [GAIN_W-1:0] gain_d;
	logic [24:0]       span_prod;
	assign rise_d    = target_q > h_q;
	assign gap_d     = rise_d ? target_q - h_q : h_q - target_q;
	assign gain_d    = rise_d ? attack_gain_q : release_gain_q;
	assign span_prod = 25'(body_span_q) * 25'(RECIP);

	// height update
	logic [LVL_W-1:0] step, h_mov, h_snap, h_next;
	logic [11:0]      qs_times_d;
	assign step       = prod_q[18:8];
	assign h_mov      = rise_q ? h_q + step : h_q - step;
	assign h_snap     = (gap_q < LVL_W'(snap_thresh_q)) ? target_q : h_mov;
	assign h_next     = (h_snap > max_height_q) ? max_height_q : h_snap;
	assign qs_times_d = 12'(qs_q) * 12'(ROW_COUNT - 1);

	// peak update
	logic [LVL_W-1:0] p_max, p_next;
	assign p_max  = (h_q > p_q) ? h_q : p_q;
	assign p_next = (p_max > LVL_W'(peak_decay_q)) ? p_max - LVL_W'(peak_decay_q) : '0;

	// peak pixel and its row
	logic [18:0] pb_prod;
	logic [11:0] top_diff;
	logic [3:0]  prow_raw;
	logic [RW-1:0] prow_c;
	assign pb_prod  = 19'(p_q) * 19'(peak_scale_q);
	assign top_diff = (12'(TOP_LVL) > 12'(p_q)) ? 12'(TOP_LVL) - 12'(p_q) : '0;
	assign prow_raw = top_diff[11:8];
	assign prow_c   = (5'(prow_raw) > 5'(ROW_COUNT - 1)) ? RW'(ROW_COUNT - 1) : RW'(prow_raw);

	// row renderer, bottom row first (d = rows above the bottom, counted upward)
	logic [12:0]      hx, bx, cov;
	logic [9:0]       body_sum;
	logic [PIX_W-1:0] body_pix, row_pix;
	logic [4:0]       y_row;
	logic [RW:0]      r_sum;
	assign hx       = 13'(h_q);
	assign bx       = 13'({d_q, 8'h00});
	assign cov      = hx - bx;
	assign body_sum = 10'(body_base_q) + 10'(q_acc_q);
	assign body_pix = (body_sum > 10'd255) ? 8'd255 : body_sum[7:0];
	assign y_row    = 5'(ROW_COUNT - 1) - 5'(d_q);
	assign r_sum    = (RW+1)'(r_acc_q) + (RW+1)'(rs_q);

	always_comb begin
		if (pnz_q && (d_q == pd_q)) begin
			row_pix = pb_q;
		end else if (hx >= bx + 13'd256) begin
			row_pix = body_pix;
		end else if (hx > bx) begin
			// (255 * cov) >> 8 is cov - 1 for 0 < cov < 256
			row_pix = cov[7:0] - 8'd1;
		end else begin
			row_pix = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAND_COUNT; i++) begin
				bar_height_q[i] <= '0;
				peak_level_q[i] <= '0;
			end
		end else begin
			if (cmd.upd_h) bar_height_q[bsel_q] <= h_next;
			if (cmd.upd_p) peak_level_q[bsel_q] <= p_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			band_q     <= band_index;
			target_q   <= target_level;
			in_range_q <= 5'(band_index) < 5'(BAND_COUNT);
			h_q        <= bar_height_q[bsel_in];
			p_q        <= peak_level_q[bsel_in];
			for (int i = 0; i < OUT_ROWS; i++) col_q[i] <= '0;
		end
		if (cmd.mul) begin
			rise_q <= rise_d;
			gap_q  <= gap_d;
			prod_q <= 19'(gap_d) * 19'(gain_d);
			qs_q   <= span_prod[DIV_SH+7:DIV_SH];
		end
		if (cmd.upd_h) begin
			h_q  <= h_next;
			rs_q <= RW'(12'(body_span_q) - qs_times_d);
		end
		if (cmd.upd_p) p_q <= p_next;
		if (cmd.peak) begin
			pb_q    <= (pb_prod[18:16] != 3'd0) ? 8'd255 : pb_prod[15:8];
			pnz_q   <= p_q != '0;
			pd_q    <= RW'(ROW_COUNT - 1) - prow_c;
			d_q     <= '0;
			q_acc_q <= '0;
			r_acc_q <= '0;
		end
		if (cmd.row) begin
			if (y_row < 5'(OUT_ROWS)) col_q[3'(y_row)] <= row_pix;
			d_q <= d_q + 1'b1;
			// running span*d/(ROW_COUNT-1): quotient and remainder step
			if (r_sum >= (RW+1)'(ROW_COUNT - 1)) begin
				q_acc_q <= q_acc_q + 9'(qs_q) + 9'd1;
				r_acc_q <= RW'(r_sum - (RW+1)'(ROW_COUNT - 1));
			end else begin
				q_acc_q <= q_acc_q + 9'(qs_q);
				r_acc_q <= RW'(r_sum);
			end
		end
		if (cmd.out_load) begin
			column_index <= band_q;
			pixel_row0   <= col_q[0];
			pixel_row1   <= col_q[1];
			pixel_row2   <= col_q[2];
			pixel_row3   <= col_q[3];
			pixel_row4   <= col_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.in_range = in_range_q;
	assign sts.row_last = d_q == RW'(ROW_COUNT - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	`PHBM_ASSERT_IMPL(a_write_in_range, cmd.upd_h || cmd.upd_p, in_range_q)
	`PHBM_ASSERT_IMPL(a_height_ceiling, cmd.upd_h, h_next <= max_height_q)
	`PHBM_ASSERT_IMPL(a_peak_row_range, cmd.row, pd_q <= RW'(ROW_COUNT - 1))
	`PHBM_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid_q)

endmodule

### hdl/peak_hold_bar_meter_top.sv
// Top level of the LED bar-graph meter with peak hold.
`timescale 1ns / 1ps

// Each input transaction carries a band index and a Q3.8 target level; the block
// moves that band's bar height toward the target (attack gain rising, release gain
// falling, snap inside the threshold, clamp at max_height), lets the band's peak
// follow and decay, and returns one transaction with the band's brightness column:
// gradient body, partial tip row, peak pixel on top. Bands beyond BAND_COUNT return
// an all-dark column and leave the state alone. An in-range transaction passes the
// multiply, height, peak, peak-pixel and row states before the hand-off, an
// out-of-range one goes from the multiply to the hand-off; the row renderer steps
// one row per cycle; attack/release and peak multiplies each have their own state.
// Results sit in an output register, so a new transaction is taken while the last
// result waits; the block only holds when a second result is ready before the
// first is taken. Configuration writes take effect at once; write them while idle.
// Band heights and peaks reset to zero, registers to their documented defaults.

module peak_hold_bar_meter_top #(
	parameter int BAND_COUNT = phbm_pkg::BAND_COUNT_DEF,
	parameter int ROW_COUNT  = phbm_pkg::ROW_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [phbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [phbm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [phbm_pkg::BAND_W-1:0]      band_index,
	input  logic [phbm_pkg::LVL_W-1:0]       target_level,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [phbm_pkg::BAND_W-1:0]      column_index,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row0,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row1,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row2,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row3,
	output logic [phbm_pkg::PIX_W-1:0]       pixel_row4
);
	import phbm_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t sts;

	// sequencer: accept, multiply, update height, update peak, render rows, hand off
	phbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, band state, arithmetic and the output register
	phbm_datapath #(
		.BAND_COUNT (BAND_COUNT),
		.ROW_COUNT  (ROW_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.band_index   (band_index),
		.target_level (target_level),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.column_index (column_index),
		.pixel_row0   (pixel_row0),
		.pixel_row1   (pixel_row1),
		.pixel_row2   (pixel_row2),
		.pixel_row3   (pixel_row3),
		.pixel_row4   (pixel_row4),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
